// ===== rtl/core/liftoff_accel_detector_assert.svh =====
// Assertion macros used by the liftoff detector tracker.
`ifndef LIFTOFF_ACCEL_DETECTOR_ASSERT_SVH
`define LIFTOFF_ACCEL_DETECTOR_ASSERT_SVH

// Clocked property check, disabled while reset is asserted.
`define LAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define LAD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/lad_pkg.sv =====
// Types and constants of the liftoff acceleration detector.
package lad_pkg;

  localparam int unsigned AxisW    = 16;
  localparam int unsigned SquareW  = 31;
  localparam int unsigned AddW     = 10;
  localparam int unsigned AddShift = 22;
  localparam int unsigned SumW     = 16;
  localparam int unsigned PosW     = 6;
  localparam int unsigned RunW     = 8;
  localparam int unsigned BlinkW   = 16;
  localparam int unsigned LenW     = 7;
  localparam int unsigned ThrW     = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [LenW-1:0]   LenMax          = 7'd64;
  localparam logic [LenW-1:0]   WindowLenRst    = 7'd20;
  localparam logic [ThrW-1:0]   AvgThresholdRst = 10'd1;
  localparam logic [RunW-1:0]   WindowLimitRst  = 8'd2;
  localparam logic [BlinkW-1:0] BlinkPeriodRst  = 16'd500;
  localparam logic [RunW-1:0]   RunMax          = 8'hFF;
  localparam logic [SumW-1:0]   SumMax          = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_OPEN  = 2'd1,
    REQ_CLOSE = 2'd2
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_LEN    = 2'd0,
    CFG_AVG_THRESHOLD = 2'd1,
    CFG_WINDOW_LIMIT  = 2'd2,
    CFG_BLINK_PERIOD  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [LenW-1:0]   window_len;
    logic [ThrW-1:0]   avg_threshold;
    logic [RunW-1:0]   window_limit;
    logic [BlinkW-1:0] blink_period;
  } cfg_t;

  typedef struct packed {
    logic      valid;
    req_type_e req;
  } stage_t;

endpackage

// ===== rtl/core/lad_square_lane.sv =====
// One axis lane: registers the square of a signed sample.
module lad_square_lane (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [lad_pkg::AxisW-1:0]    sample_i,
  output logic        [lad_pkg::SquareW-1:0]  square_o
);
  import lad_pkg::*;

  logic signed [2*AxisW-1:0] prod;
  logic        [SquareW-1:0] square_q;

  // The square of a 16-bit signed value is at most 2**30 and fits 31 bits.
  assign prod = sample_i * sample_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      square_q <= prod[SquareW-1:0];
    end
  end

  assign square_o = square_q;

endmodule

// ===== rtl/core/lad_merge.sv =====
// Merges the three lane squares into the coarse magnitude increment.
module lad_merge (
  input  logic [lad_pkg::SquareW-1:0] sq_x_i,
  input  logic [lad_pkg::SquareW-1:0] sq_y_i,
  input  logic [lad_pkg::SquareW-1:0] sq_z_i,
  output logic [lad_pkg::AddW-1:0]    add_o
);
  import lad_pkg::*;

  // Three squares of at most 2**30 each stay below 2**32.
  logic [SquareW:0] total;

  assign total = (SquareW+1)'(sq_x_i) + (SquareW+1)'(sq_y_i) + (SquareW+1)'(sq_z_i);
  assign add_o = total[AddShift +: AddW];

endmodule

// ===== rtl/core/lad_tracker.sv =====
// Window, run, flag and LED state, updated once per processed transaction.
`include "liftoff_accel_detector_assert.svh"

module lad_tracker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     proc_i,
  input  lad_pkg::req_type_e       req_i,
  input  logic [lad_pkg::AddW-1:0] add_i,
  input  lad_pkg::cfg_t            cfg_i,
  output logic                     led_on_o,
  output logic                     launch_flag_o,
  output logic                     detected_now_o
);
  import lad_pkg::*;

  logic [SumW-1:0]   sum_q, sum_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [RunW-1:0]   run_q, run_d;
  logic              flag_q, flag_d;
  logic [BlinkW-1:0] blink_q, blink_d;
  logic              led_q, led_d;
  logic              phase_q, phase_d;
  logic              det_q, det_d;

  logic [LenW-1:0]   len_eff;
  logic [ThrW:0]     thr_p1;
  logic [17:0]       pass_level;
  logic [SumW:0]     sum_acc;
  logic [SumW-1:0]   sum_sat;
  logic              check_due;
  logic              window_pass;
  logic [RunW-1:0]   run_inc;
  logic [LenW-1:0]   pos_inc;

  always_comb begin
    if (cfg_i.window_len == '0) begin
      len_eff = LenW'(1);
    end else if (cfg_i.window_len > LenMax) begin
      len_eff = LenMax;
    end else begin
      len_eff = cfg_i.window_len;
    end
  end

  // floor(sum / len) > thr holds exactly when sum >= (thr + 1) * len.
  assign thr_p1      = (ThrW+1)'(cfg_i.avg_threshold) + (ThrW+1)'(1);
  assign pass_level  = 18'(thr_p1) * 18'(len_eff);
  assign sum_acc     = (SumW+1)'(sum_q) + (SumW+1)'(add_i);
  assign sum_sat     = sum_acc[SumW] ? SumMax : sum_acc[SumW-1:0];
  assign check_due   = (pos_q == PosW'(1)) && (len_eff > LenW'(1));
  assign window_pass = 18'(sum_sat) >= pass_level;
  assign run_inc     = (run_q < RunMax) ? run_q + RunW'(1) : run_q;
  assign pos_inc     = LenW'(pos_q) + LenW'(1);

  always_comb begin
    sum_d   = sum_q;
    pos_d   = pos_q;
    run_d   = run_q;
    flag_d  = flag_q;
    blink_d = blink_q;
    led_d   = led_q;
    phase_d = phase_q;
    det_d   = 1'b0;
    unique case (req_i)
      REQ_OPEN: begin
        flag_d = 1'b0;
      end
      REQ_CLOSE: begin
        flag_d = 1'b1;
      end
      REQ_TICK: begin
        sum_d = sum_sat;
        if (check_due) begin
          if (window_pass) begin
            run_d = run_inc;
            if (run_inc > cfg_i.window_limit) begin
              flag_d = 1'b1;
              det_d  = 1'b1;
            end
          end else begin
            run_d = '0;
          end
          sum_d = '0;
        end
        if (blink_q >= cfg_i.blink_period) begin
          blink_d = BlinkW'(1);
          if (flag_d) begin
            phase_d = !phase_q;
            led_d   = !phase_q;
          end else begin
            led_d = 1'b1;
          end
        end else begin
          blink_d = blink_q + BlinkW'(1);
        end
        pos_d = (pos_inc >= len_eff) ? '0 : pos_inc[PosW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      pos_q   <= '0;
      run_q   <= '0;
      flag_q  <= 1'b0;
      blink_q <= '0;
      led_q   <= 1'b0;
      phase_q <= 1'b0;
      det_q   <= 1'b0;
    end else if (proc_i) begin
      sum_q   <= sum_d;
      pos_q   <= pos_d;
      run_q   <= run_d;
      flag_q  <= flag_d;
      blink_q <= blink_d;
      led_q   <= led_d;
      phase_q <= phase_d;
      det_q   <= det_d;
    end
  end

  assign led_on_o       = led_q;
  assign launch_flag_o  = flag_q;
  assign detected_now_o = det_q;

  `LAD_ASSERT(a_det_sets_flag, det_q |-> flag_q, "detection reported without the flag")
  `LAD_ASSERT(a_hold_when_idle, !proc_i |=> $stable({led_q, flag_q, det_q, run_q, pos_q}),
              "state changed without a processed transaction")
  `LAD_ASSERT(a_check_clears_sum, proc_i && (req_i == REQ_TICK) && check_due |=> sum_q == '0,
              "window sum not cleared after the window check")

endmodule

// ===== rtl/core/liftoff_accel_detector.sv =====
// Top level of the liftoff acceleration detector.
// Usage: each input transaction carries a request type and three signed
// accelerometer axes. A sample tick adds the coarse squared magnitude to the
// running window sum and may run the window check; open and close commands
// clear or set the launch flag without advancing time. Every input
// transaction yields exactly one output transaction with the LED level, the
// launch flag and a detection mark set only by the detecting transaction.
// Pipeline: stage one squares the three axes in parallel lanes; stage two
// merges the lane squares and updates the detector state, whose registers
// are the output payload. A result passes the lane square and tracker state
// registers before it is valid; one transaction per cycle is sustained
// without receiver stalls, set by the single state update in stage two.
// When the receiver stalls a valid output, it holds and both stages freeze;
// the input stall rises in that same cycle, so nothing is lost or repeated.
// Configuration writes are registered and should be made while idle.
// Reset clears the pipeline, the counters, the flag and turns the LED off,
// and loads the default register values.
module liftoff_accel_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          req_type_i,
  input  logic signed [lad_pkg::AxisW-1:0]    accel_x_i,
  input  logic signed [lad_pkg::AxisW-1:0]    accel_y_i,
  input  logic signed [lad_pkg::AxisW-1:0]    accel_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                led_on_o,
  output logic                                launch_flag_o,
  output logic                                detected_now_o,
  input  logic                                cfg_we_i,
  input  logic [lad_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [lad_pkg::CfgDataW-1:0]        cfg_data_i
);
  import lad_pkg::*;

  cfg_t   cfg_q;
  stage_t s1_q;
  logic   out_valid_q;
  logic   advance;

  logic [SquareW-1:0] sq_x, sq_y, sq_z;
  logic [AddW-1:0]    add;

  // Both stages move together whenever the output register is free or
  // being drained this cycle.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len    <= WindowLenRst;
      cfg_q.avg_threshold <= AvgThresholdRst;
      cfg_q.window_limit  <= WindowLimitRst;
      cfg_q.blink_period  <= BlinkPeriodRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WINDOW_LEN:    cfg_q.window_len    <= cfg_data_i[LenW-1:0];
        CFG_AVG_THRESHOLD: cfg_q.avg_threshold <= cfg_data_i[ThrW-1:0];
        CFG_WINDOW_LIMIT:  cfg_q.window_limit  <= cfg_data_i[RunW-1:0];
        CFG_BLINK_PERIOD:  cfg_q.blink_period  <= cfg_data_i[BlinkW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stage one control: the request type travels beside the lane squares.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q.valid  <= 1'b0;
      s1_q.req    <= REQ_TICK;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_q.valid  <= in_valid_i;
      s1_q.req    <= req_type_e'(req_type_i);
      out_valid_q <= s1_q.valid;
    end
  end

  lad_square_lane u_lane_x (
    .clk_i    (clk_i),
    .en_i     (advance),
    .sample_i (accel_x_i),
    .square_o (sq_x)
  );

  lad_square_lane u_lane_y (
    .clk_i    (clk_i),
    .en_i     (advance),
    .sample_i (accel_y_i),
    .square_o (sq_y)
  );

  lad_square_lane u_lane_z (
    .clk_i    (clk_i),
    .en_i     (advance),
    .sample_i (accel_z_i),
    .square_o (sq_z)
  );

  lad_merge u_merge (
    .sq_x_i (sq_x),
    .sq_y_i (sq_y),
    .sq_z_i (sq_z),
    .add_o  (add)
  );

  // The tracker state doubles as the output register.
  lad_tracker u_tracker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .proc_i         (advance && s1_q.valid),
    .req_i          (s1_q.req),
    .add_i          (add),
    .cfg_i          (cfg_q),
    .led_on_o       (led_on_o),
    .launch_flag_o  (launch_flag_o),
    .detected_now_o (detected_now_o)
  );

  assign out_valid_o = out_valid_q;

endmodule
